/* rtl/core/mpsg_pkg.sv */
// Shared types, constants and helper functions of the motion profile setpoint generator.
// No dependencies; every other file of the block but mpsg_cfg_if uses this package.
package mpsg_pkg;

	localparam int POS_W                = 22;
	localparam int POS_FRAC_BITS        = 16;
	localparam int SINE_TABLE_SIZE_DEF  = 256;
	localparam int DIV_W                = 48;
	localparam int W_W                  = 18;

	localparam logic signed [POS_W-1:0] RESET_SETPOINT =
		POS_W'((64'd471 << POS_FRAC_BITS) / 64'd100);
	localparam logic signed [63:0] POS_MAX = 64'sd2097151;
	localparam logic signed [63:0] POS_MIN = -64'sd2097152;

	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// cos(x) in Q30 for x in [0, pi/2], Taylor series
	function automatic longint cos_q30(input longint x);
		longint x2;
		longint term;
		longint sum;
		x2   = (x * x + (ONE_Q30 >>> 1)) >>> 30;
		term = ONE_Q30;
		sum  = term;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >>> 30) / COS_DIV[k-1];
			sum  = k[0] ? sum - term : sum + term;
		end
		return sum;
	endfunction

	function automatic logic signed [POS_W-1:0] sat22(input logic signed [63:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_MAX[POS_W-1:0];
		end else if (v < POS_MIN) begin
			r = POS_MIN[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	// magnitude rounded half up after a right shift by k
	function automatic logic [63:0] rnd_shift(input logic [63:0] v, input int k);
		logic [63:0] half;
		half = 64'd1 << (k - 1);
		return (v + half) >> k;
	endfunction

	function automatic logic signed [63:0] apply_sign(input logic [63:0] mag, input logic neg);
		logic signed [63:0] s;
		s = $signed(mag);
		return neg ? -s : s;
	endfunction

endpackage

/* rtl/core/mpsg_req_if.sv */
// Request channel of the setpoint generator: command beat with move fields.
// Depends on mpsg_pkg for the position width.
interface mpsg_req_if;
	logic                              valid;
	logic                              ready;
	logic                              cmd;
	logic [31:0]                       now_ms;
	logic signed [mpsg_pkg::POS_W-1:0] goal_pos;
	logic [15:0]                       move_time;
	logic [15:0]                       ramp_time;
	logic signed [mpsg_pkg::POS_W-1:0] start_pos;

	modport source (output valid, cmd, now_ms, goal_pos, move_time, ramp_time, start_pos,
		input ready);
	modport sink (input valid, cmd, now_ms, goal_pos, move_time, ramp_time, start_pos,
		output ready);
endinterface

/* rtl/core/mpsg_rsp_if.sv */
// Result channel of the setpoint generator: setpoint, moving flag and phase per beat.
// Depends on mpsg_pkg for the position width.
interface mpsg_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [mpsg_pkg::POS_W-1:0] setpoint;
	logic                              moving;
	logic [1:0]                        phase;

	modport source (output valid, setpoint, moving, phase, input ready);
	modport sink (input valid, setpoint, moving, phase, output ready);
endinterface

/* rtl/core/mpsg_cfg_if.sv */
// Configuration write channel of the setpoint generator: ramp mode register.
// No dependencies.
interface mpsg_cfg_if;
	logic valid;
	logic ready;
	logic ramp_mode;

	modport source (output valid, ramp_mode, input ready);
	modport sink (input valid, ramp_mode, output ready);
endinterface

/* rtl/core/mpsg_alu.sv */
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// Depends on mpsg_pkg for the request struct and divider width.
module mpsg_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  mpsg_pkg::alu_req_t req,
	input  logic [63:0]        opa,
	input  logic [63:0]        opb,
	output logic               done,
	output logic [63:0]        result
);
	import mpsg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      acc_q;
	logic [63:0]      mc_q;
	logic [63:0]      mp_q;
	logic [DIV_W:0]   trial;
	logic             last;

	assign trial = {acc_q[DIV_W-1:0], mc_q[DIV_W-1]} - {1'b0, mp_q[DIV_W-1:0]};
	assign last  = (op_q == ALU_MUL) ? (mp_q == 64'd0) : (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= 64'd0;
			mc_q  <= opa;
			mp_q  <= opb;
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					if (mp_q != 64'd0) begin
						if (mp_q[0]) begin
							acc_q <= acc_q + mc_q;
						end
						mc_q <= mc_q << 1;
						mp_q <= mp_q >> 1;
					end
				end
				ALU_DIV: begin
					if (!trial[DIV_W]) begin
						acc_q <= 64'(trial[DIV_W-1:0]);
						mc_q  <= {mc_q[62:0], 1'b1};
					end else begin
						acc_q <= 64'({acc_q[DIV_W-2:0], mc_q[DIV_W-1]});
						mc_q  <= {mc_q[62:0], 1'b0};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == ALU_DIV) ? 64'(mc_q[DIV_W-1:0]) : acc_q;

endmodule

/* rtl/core/motion_profile_setpoint_generator.sv */
// Top level of the trapezoidal / S-curve position setpoint generator.
// Depends on mpsg_pkg, mpsg_req_if, mpsg_rsp_if, mpsg_cfg_if and mpsg_alu.
//
// Usage:
//   req carries one beat per item: cmd 1 starts a move (goal, total and ramp time,
//   measured start angle, time stamp), cmd 0 is a tick with the current time stamp.
//   Every request beat yields exactly one rsp beat: setpoint (Q5.16, saturated),
//   moving and phase (0 idle, 1 accelerate, 2 cruise, 3 decelerate).
//   cfg writes the ramp mode (0 linear, 1 sine S-curve); it is always ready and
//   should only be written while no item is in flight.
// Arithmetic: all arithmetic runs on one shared shift-add multiplier / restoring
//   divider; a multiply runs over the multiplier bits (up to 18). A start beat
//   with a nonzero ramp time adds two divides and three multiplies.
//   req.ready is high only while the sequencer is idle, one item at a time.
// Reset: setpoint returns to 4.71 rad, moving clears, mode is linear.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile but its result is held until rsp.ready frees that register.
module motion_profile_setpoint_generator #(
	parameter int SINE_TABLE_SIZE = mpsg_pkg::SINE_TABLE_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mpsg_req_if.sink   req,
	mpsg_rsp_if.source rsp,
	mpsg_cfg_if.sink   cfg
);
	import mpsg_pkg::*;

	localparam int          IDX_W     = $clog2(SINE_TABLE_SIZE + 1);
	localparam logic [63:0] TBL_SCALE = 64'(2 * SINE_TABLE_SIZE);

	typedef enum logic [14:0] {
		ST_IDLE      = 15'b000000000000001,
		ST_DIV_PEAK  = 15'b000000000000010,
		ST_MUL_DEN   = 15'b000000000000100,
		ST_DIV_SLOPE = 15'b000000000001000,
		ST_MUL_REND  = 15'b000000000010000,
		ST_MUL_CEND  = 15'b000000000100000,
		ST_EVAL      = 15'b000000001000000,
		ST_MUL_LIN   = 15'b000000010000000,
		ST_MUL_S1    = 15'b000000100000000,
		ST_MUL_S2    = 15'b000001000000000,
		ST_DIV_IDX   = 15'b000010000000000,
		ST_TBL_RD    = 15'b000100000000000,
		ST_MUL_W     = 15'b001000000000000,
		ST_APPLY     = 15'b010000000000000,
		ST_FIN       = 15'b100000000000000
	} state_t;

	function automatic logic [W_W-1:0] sine_entry(input int i);
		longint c;
		longint v;
		longint r;
		if (2 * i <= SINE_TABLE_SIZE) begin
			c = cos_q30((PI_Q30 * longint'(i) + SINE_TABLE_SIZE / 2) / SINE_TABLE_SIZE);
			v = ONE_Q30 - c;
		end else begin
			c = cos_q30((PI_Q30 * longint'(SINE_TABLE_SIZE - i) + SINE_TABLE_SIZE / 2)
				/ SINE_TABLE_SIZE);
			v = ONE_Q30 + c;
		end
		if (v >= 0) begin
			r = (v + 64'sd8192) >>> 14;
		end else begin
			r = -((-v + 64'sd8192) >>> 14);
		end
		return r[W_W-1:0];
	endfunction

	logic [W_W-1:0] sine_tbl [SINE_TABLE_SIZE+1];

	for (genvar g = 0; g <= SINE_TABLE_SIZE; g++) begin : g_tbl
		assign sine_tbl[g] = sine_entry(g);
	end

	state_t                  state_q;
	logic                    issued_q;
	logic                    mode_q;
	logic                    moving_q;
	logic signed [POS_W-1:0] setp_q;
	logic                    rsp_valid_q;
	logic signed [POS_W-1:0] rsp_setp_q;
	logic                    rsp_moving_q;
	logic [1:0]              rsp_phase_q;

	logic [31:0]             now_q;
	logic [31:0]             t0_q;
	logic signed [POS_W-1:0] goal_q;
	logic signed [POS_W-1:0] spos_q;
	logic [15:0]             rdur_q;
	logic [15:0]             cdur_q;
	logic [16:0]             den_q;
	logic                    neg_q;
	logic [POS_W-1:0]        dmag_q;
	logic [63:0]             prod_q;
	logic [39:0]             pmag_q;
	logic [DIV_W-1:0]        smag_q;
	logic signed [POS_W-1:0] rend_q;
	logic signed [POS_W-1:0] cend_q;
	logic [15:0]             x_q;
	logic [1:0]              ph_q;
	logic signed [63:0]      off_q;
	logic [63:0]             m_q;
	logic [IDX_W-1:0]        idx_q;
	logic [W_W-1:0]          w_q;

	logic signed [POS_W:0]   d_w;
	logic [16:0]             rt2_w;
	logic [15:0]             cru_w;
	logic [31:0]             t_w;
	logic [31:0]             rc_w;
	logic [31:0]             rrc_w;
	logic                    alu_state;
	alu_req_t                alu_req;
	logic [63:0]             opa;
	logic [63:0]             opb;
	logic                    alu_done;
	logic [63:0]             alu_res;
	logic [63:0]             ramp_mag;
	logic signed [63:0]      ramp_term;
	logic signed [63:0]      lin_base;
	logic                    rsp_free;
	logic                    rsp_load;
	logic                    req_beat;

	assign req_beat = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign rsp_load = (state_q == ST_FIN) && rsp_free;

	assign d_w   = (POS_W+1)'(req.goal_pos) - (POS_W+1)'(req.start_pos);
	assign rt2_w = {req.ramp_time, 1'b0};
	assign cru_w = (rt2_w < {1'b0, req.move_time}) ? 16'({1'b0, req.move_time} - rt2_w) : 16'd0;

	assign t_w   = now_q - t0_q;
	assign rc_w  = 32'(rdur_q) + 32'(cdur_q);
	assign rrc_w = rc_w + 32'(rdur_q);

	assign alu_state = (state_q == ST_DIV_PEAK) || (state_q == ST_MUL_DEN)
		|| (state_q == ST_DIV_SLOPE) || (state_q == ST_MUL_REND) || (state_q == ST_MUL_CEND)
		|| (state_q == ST_MUL_LIN) || (state_q == ST_MUL_S1) || (state_q == ST_MUL_S2)
		|| (state_q == ST_DIV_IDX) || (state_q == ST_MUL_W);

	assign alu_req.start = alu_state && !issued_q;
	assign alu_req.op    = (state_q == ST_DIV_PEAK || state_q == ST_DIV_SLOPE
		|| state_q == ST_DIV_IDX) ? ALU_DIV : ALU_MUL;

	always_comb begin
		opa = 64'd0;
		opb = 64'd0;
		unique case (state_q)
			ST_DIV_PEAK: begin
				opa = (64'(dmag_q) << 16) + 64'(den_q[16:1]);
				opb = 64'(den_q);
			end
			ST_MUL_DEN: begin
				opa = 64'(den_q);
				opb = 64'(rdur_q);
			end
			ST_DIV_SLOPE: begin
				opa = (64'(dmag_q) << 24) + (prod_q >> 1);
				opb = prod_q;
			end
			ST_MUL_REND: begin
				opa = 64'(pmag_q);
				opb = 64'(rdur_q);
			end
			ST_MUL_CEND: begin
				opa = 64'(pmag_q);
				opb = 64'(cdur_q);
			end
			ST_MUL_LIN: begin
				opa = 64'(pmag_q);
				opb = 64'(x_q);
			end
			ST_MUL_S1: begin
				opa = 64'(smag_q);
				opb = 64'(x_q);
			end
			ST_MUL_S2: begin
				opa = m_q;
				opb = 64'(x_q);
			end
			ST_DIV_IDX: begin
				opa = 64'(x_q) * TBL_SCALE + 64'(rdur_q);
				opb = 64'({rdur_q, 1'b0});
			end
			ST_MUL_W: begin
				opa = rnd_shift(m_q, 8);
				opb = 64'(w_q);
			end
			default: begin
			end
		endcase
	end

	mpsg_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.result (alu_res)
	);

	assign ramp_mag  = (state_q == ST_MUL_W) ? rnd_shift(alu_res, 34) : rnd_shift(alu_res, 25);
	assign ramp_term = apply_sign(ramp_mag, neg_q);
	assign lin_base  = (ph_q == 2'd2) ? 64'(rend_q) : 64'(cend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			mode_q      <= 1'b0;
			moving_q    <= 1'b0;
			setp_q      <= RESET_SETPOINT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.ramp_mode;
			end
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end
			if (alu_done) begin
				issued_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_beat) begin
						if (!req.cmd) begin
							state_q <= ST_EVAL;
						end else if (req.ramp_time == 16'd0) begin
							moving_q <= 1'b0;
							setp_q   <= req.goal_pos;
							state_q  <= ST_EVAL;
						end else begin
							moving_q <= 1'b1;
							state_q  <= ST_DIV_PEAK;
						end
					end
				end
				ST_DIV_PEAK:  if (alu_done) state_q <= ST_MUL_DEN;
				ST_MUL_DEN:   if (alu_done) state_q <= ST_DIV_SLOPE;
				ST_DIV_SLOPE: if (alu_done) state_q <= ST_MUL_REND;
				ST_MUL_REND:  if (alu_done) state_q <= ST_MUL_CEND;
				ST_MUL_CEND:  if (alu_done) state_q <= ST_EVAL;
				ST_EVAL: begin
					if (!moving_q || rdur_q == 16'd0) begin
						moving_q <= 1'b0;
						state_q  <= ST_FIN;
					end else if (t_w <= 32'(rdur_q)) begin
						state_q <= ST_MUL_S1;
					end else if (t_w <= rrc_w) begin
						state_q <= ST_MUL_LIN;
					end else begin
						setp_q   <= goal_q;
						moving_q <= 1'b0;
						state_q  <= ST_FIN;
					end
				end
				ST_MUL_LIN: begin
					if (alu_done) begin
						state_q <= (ph_q == 2'd2) ? ST_APPLY : ST_MUL_S1;
					end
				end
				ST_MUL_S1: if (alu_done) state_q <= ST_MUL_S2;
				ST_MUL_S2: begin
					if (alu_done) begin
						state_q <= mode_q ? ST_DIV_IDX : ST_APPLY;
					end
				end
				ST_DIV_IDX: if (alu_done) state_q <= ST_TBL_RD;
				ST_TBL_RD:  state_q <= ST_MUL_W;
				ST_MUL_W:   if (alu_done) state_q <= ST_APPLY;
				ST_APPLY: begin
					setp_q  <= sat22(64'(spos_q) + off_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_beat) begin
					now_q <= req.now_ms;
					ph_q  <= 2'd0;
					if (req.cmd) begin
						goal_q <= req.goal_pos;
						spos_q <= req.start_pos;
						t0_q   <= req.now_ms;
						rdur_q <= req.ramp_time;
						cdur_q <= cru_w;
						den_q  <= 17'(req.ramp_time) + 17'(cru_w);
						neg_q  <= d_w[POS_W];
						dmag_q <= d_w[POS_W] ? POS_W'(-d_w) : POS_W'(d_w);
						pmag_q <= '0;
						smag_q <= '0;
						rend_q <= '0;
						cend_q <= '0;
					end
				end
			end
			ST_DIV_PEAK:  if (alu_done) pmag_q <= alu_res[39:0];
			ST_MUL_DEN:   if (alu_done) prod_q <= alu_res;
			ST_DIV_SLOPE: if (alu_done) smag_q <= alu_res[DIV_W-1:0];
			ST_MUL_REND: begin
				if (alu_done) begin
					rend_q <= sat22(apply_sign(rnd_shift(alu_res, 17), neg_q));
				end
			end
			ST_MUL_CEND: begin
				if (alu_done) begin
					cend_q <= sat22(64'(rend_q) + apply_sign(rnd_shift(alu_res, 16), neg_q));
				end
			end
			ST_EVAL: begin
				off_q <= 64'sd0;
				if (moving_q && rdur_q != 16'd0) begin
					if (t_w <= 32'(rdur_q)) begin
						ph_q <= 2'd1;
						x_q  <= t_w[15:0];
					end else if (t_w <= rc_w) begin
						ph_q <= 2'd2;
						x_q  <= 16'(t_w - 32'(rdur_q));
					end else begin
						ph_q <= (t_w <= rrc_w) ? 2'd3 : 2'd0;
						x_q  <= 16'(t_w - rc_w);
					end
				end
			end
			ST_MUL_LIN: begin
				if (alu_done) begin
					off_q <= lin_base + apply_sign(rnd_shift(alu_res, 16), neg_q);
				end
			end
			ST_MUL_S1: if (alu_done) m_q <= alu_res;
			ST_MUL_S2, ST_MUL_W: begin
				if (alu_done) begin
					m_q <= alu_res;
					if (state_q == ST_MUL_W || !mode_q) begin
						off_q <= (ph_q == 2'd3) ? off_q - ramp_term : off_q + ramp_term;
					end
				end
			end
			ST_DIV_IDX: if (alu_done) idx_q <= alu_res[IDX_W-1:0];
			ST_TBL_RD:  w_q <= sine_tbl[idx_q];
			ST_FIN: begin
				if (rsp_free) begin
					rsp_setp_q   <= setp_q;
					rsp_moving_q <= moving_q;
					rsp_phase_q  <= ph_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.setpoint = rsp_setp_q;
	assign rsp.moving   = rsp_moving_q;
	assign rsp.phase    = rsp_phase_q;

endmodule

/* verif/motion_profile_setpoint_generator_checker.sv */
// Result checker for the motion profile setpoint generator: watches req, rsp and cfg beats,
// predicts each setpoint/moving/phase result and compares in order. Depends on mpsg_pkg
// and the mpsg_req_if, mpsg_rsp_if and mpsg_cfg_if interfaces.
module motion_profile_setpoint_generator_checker #(
	parameter int TBL_N = mpsg_pkg::SINE_TABLE_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mpsg_req_if        req,
	mpsg_rsp_if        rsp,
	mpsg_cfg_if        cfg,
	output int         errors,
	output int         pending
);
	import mpsg_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [POS_W-1:0] setpoint;
		logic                    moving;
		logic [1:0]              phase;
	} setpoint_beat_t;

	setpoint_beat_t setpoint_q[$];

	longint    cosine_table [TBL_N+1];
	logic      s_curve;
	logic      in_move;
	longint    held_pos;
	longint    origin_pos;
	longint    target_pos;
	bit [31:0] move_t0;
	longint    ramp_ms;
	longint    cruise_ms;
	longint    peak_vel;
	longint    accel;
	longint    ramp_end_pos;
	longint    cruise_end_pos;

	function automatic wide_t round_div(wide_t n, wide_t d);
		wide_t h;
		h = d / 2;
		if (n >= 0) begin
			return (n + h) / d;
		end
		return -((-n + h) / d);
	endfunction

	function automatic longint clamp_pos(wide_t v);
		if (v > 2097151) begin
			return 2097151;
		end
		if (v < -2097152) begin
			return -2097152;
		end
		return longint'(v);
	endfunction

	function automatic longint taylor_cos(longint x);
		longint x2;
		longint term;
		longint sum;
		x2   = (x * x + (longint'(1) << 29)) >>> 30;
		term = longint'(1) << 30;
		sum  = term;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * x2) >>> 30) / ((2 * k - 1) * (2 * k));
			sum  = (k % 2 == 1) ? sum - term : sum + term;
		end
		return sum;
	endfunction

	initial begin
		longint c;
		for (int i = 0; i <= TBL_N; i++) begin
			if (2 * i <= TBL_N) begin
				c = taylor_cos((PI_Q30 * i + TBL_N / 2) / TBL_N);
				cosine_table[i] = round_div((longint'(1) << 30) - c, longint'(1) << 14);
			end else begin
				c = taylor_cos((PI_Q30 * (TBL_N - i) + TBL_N / 2) / TBL_N);
				cosine_table[i] = round_div((longint'(1) << 30) + c, longint'(1) << 14);
			end
		end
	end

	function automatic wide_t ramp_offset(longint t);
		wide_t  p;
		longint idx;
		p = wide_t'(accel) * t * t;
		if (!s_curve) begin
			return round_div(p, wide_t'(1) << 25);
		end
		idx = (t * TBL_N * 2 + ramp_ms) / (2 * ramp_ms);
		if (idx > TBL_N) begin
			idx = TBL_N;
		end
		return round_div(round_div(p, 256) * cosine_table[idx], wide_t'(1) << 34);
	endfunction

	function automatic setpoint_beat_t next_setpoint(logic cmd, bit [31:0] now,
			longint goal, longint mt, longint rt, longint from);
		setpoint_beat_t b;
		bit [31:0]      el;
		longint         t;
		wide_t          off;
		longint         d;
		b.phase = 0;
		if (cmd) begin
			target_pos = goal;
			origin_pos = from;
			move_t0    = now;
			ramp_ms    = rt;
			cruise_ms  = (2 * rt < mt) ? mt - 2 * rt : 0;
			peak_vel = 0; accel = 0; ramp_end_pos = 0; cruise_end_pos = 0;
			if (rt == 0) begin
				in_move  = 0;
				held_pos = target_pos;
			end else begin
				d = target_pos - origin_pos;
				peak_vel = round_div(wide_t'(d) * 65536, rt + cruise_ms);
				accel = round_div(wide_t'(d) * 16777216, wide_t'(rt + cruise_ms) * rt);
				ramp_end_pos = clamp_pos(round_div(wide_t'(peak_vel) * rt, 131072));
				cruise_end_pos = clamp_pos(ramp_end_pos +
					round_div(wide_t'(peak_vel) * cruise_ms, 65536));
				in_move = 1;
			end
		end
		if (in_move && ramp_ms != 0) begin
			el = now - move_t0;
			t  = el;
			if (t <= ramp_ms) begin
				off = ramp_offset(t);
				b.phase = 1;
			end else if (t <= ramp_ms + cruise_ms) begin
				off = ramp_end_pos + round_div(wide_t'(peak_vel) * (t - ramp_ms), 65536);
				b.phase = 2;
			end else if (t <= 2 * ramp_ms + cruise_ms) begin
				t = t - ramp_ms - cruise_ms;
				off = cruise_end_pos + round_div(wide_t'(peak_vel) * t, 65536) - ramp_offset(t);
				b.phase = 3;
			end else begin
				held_pos = target_pos;
				in_move  = 0;
			end
			if (b.phase != 0) begin
				held_pos = clamp_pos(origin_pos + off);
			end
		end else begin
			in_move = 0;
		end
		b.setpoint = held_pos[POS_W-1:0];
		b.moving   = in_move;
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		setpoint_beat_t want;
		setpoint_beat_t got;
		if (!arst_n) begin
			s_curve = 0; in_move = 0; held_pos = RESET_SETPOINT;
			origin_pos = 0; target_pos = 0; move_t0 = 0; ramp_ms = 0; cruise_ms = 0;
			peak_vel = 0; accel = 0; ramp_end_pos = 0; cruise_end_pos = 0;
			setpoint_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				s_curve = cfg.ramp_mode;
			end
			if (req.valid && req.ready) begin
				setpoint_q.push_back(next_setpoint(req.cmd, req.now_ms, req.goal_pos,
					req.move_time, req.ramp_time, req.start_pos));
			end
			if (rsp.valid && rsp.ready) begin
				got.setpoint = rsp.setpoint;
				got.moving   = rsp.moving;
				got.phase    = rsp.phase;
				if (setpoint_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected rsp beat: sp=%0d moving=%0b phase=%0d",
							got.setpoint, got.moving, got.phase);
					end
				end else begin
					want = setpoint_q.pop_front();
					if (got.setpoint !== want.setpoint || got.moving !== want.moving ||
							got.phase !== want.phase) begin
						errors++;
						if (errors <= 10) begin
							$display("rsp mismatch: exp sp=%0d moving=%0b phase=%0d, got sp=%0d moving=%0b phase=%0d",
								want.setpoint, want.moving, want.phase,
								got.setpoint, got.moving, got.phase);
						end
					end
				end
			end
			pending = setpoint_q.size();
		end
	end
endmodule

/* verif/motion_profile_setpoint_generator_test.sv */
// Testbench top of the motion profile setpoint generator: drives directed and random
// moves and ticks with idle gaps and result stalls, and reports the checker's verdict.
// Depends on mpsg_pkg, the three channel interfaces, the generator top and the checker module.
module motion_profile_setpoint_generator_test;
	import mpsg_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   errors;
	int   pending;
	int   idle_cycles = 0;
	bit   no_pressure = 0;
	int   stall_left = 0;
	int   n_items = 0;

	mpsg_req_if req();
	mpsg_rsp_if rsp();
	mpsg_cfg_if cfg();

	motion_profile_setpoint_generator u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	motion_profile_setpoint_generator_checker u_chk (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp), .cfg(cfg), .errors(errors), .pending(pending));

	always #10 clk = ~clk;

	initial begin
		req.valid = 0; req.cmd = 0; req.now_ms = 0; req.goal_pos = 0;
		req.move_time = 0; req.ramp_time = 0; req.start_pos = 0;
		rsp.ready = 0;
		cfg.valid = 0; cfg.ramp_mode = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else if (stall_left > 0) begin
			rsp.ready  <= 0;
			stall_left <= stall_left - 1;
		end else begin
			rsp.ready <= 1;
			if (!no_pressure && $urandom_range(0, 9) < 3) begin
				stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
					: $urandom_range(20, 250);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(logic cmd, bit [31:0] now, logic signed [POS_W-1:0] goal,
			bit [15:0] mt, bit [15:0] rt, logic signed [POS_W-1:0] from);
		int r;
		int gap;
		r = $urandom_range(0, 9);
		gap = (no_pressure || r < 6) ? 0 : (r < 9 ? $urandom_range(1, 4) : $urandom_range(10, 250));
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1; req.cmd <= cmd; req.now_ms <= now; req.goal_pos <= goal;
		req.move_time <= mt; req.ramp_time <= rt; req.start_pos <= from;
		do @(posedge clk); while (!req.ready);
		n_items++;
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		drain();
		cfg.valid <= 1;
		cfg.ramp_mode <= m;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
	endtask

	// start at t0, then the given number of ticks, each a random step of up to span/12 + 1 later
	task automatic run_move(bit [31:0] t0, logic signed [POS_W-1:0] goal, bit [15:0] mt,
			bit [15:0] rt, logic signed [POS_W-1:0] from, int ticks);
		bit [31:0] now;
		int        span;
		int        step;
		now  = t0;
		span = (2 * rt < mt) ? mt : 2 * rt;
		step = span / 12 + 1;
		send(1, now, goal, mt, rt, from);
		for (int k = 0; k < ticks; k++) begin
			now = now + $urandom_range(1, step);
			send(0, now, POS_W'($urandom), 16'($urandom), 16'($urandom), POS_W'($urandom));
		end
	endtask

	initial begin
		bit [15:0] rt;
		bit [15:0] mt;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(0, 32'd5, 0, 0, 0, 0);
		run_move(32'd100, 22'sh1FFFFF, 16'd40, 16'd0, 22'sh200000, 1);
		run_move(32'd200, 22'sd65536, 16'd40, 16'd10, -22'sd65536, 6);
		run_move(32'd300, -22'sd300000, 16'd10, 16'd8, 22'sd1000, 4);
		run_move(32'd400, 22'sh1FFFFF, 16'd4, 16'd1, 22'sh200000, 4);
		run_move(32'hFFFF_FFF0, 22'sd5000, 16'd30, 16'd10, 22'sd0, 4);
		send(1, 32'hFFFF_FFFF, 22'sh200000, 16'hFFFF, 16'hFFFF, 22'sh1FFFFF);
		send(0, 32'h0000_FFFF, 0, 0, 0, 0);
		write_mode(1);
		run_move(32'd1000, 22'sd200000, 16'd60, 16'd20, -22'sd200000, 5);
		run_move(32'd2000, -22'sh200000, 16'd300, 16'd255, 22'sh1FFFFF, 3);

		for (int ph = 0; ph < 6 && n_items < 1500; ph++) begin
			write_mode(ph % 2 == 0 ? 0 : 1);
			no_pressure = (ph == 2);
			while (n_items < 250 * (ph + 1) + 30) begin
				rt = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
				if (ph % 2 == 0 && $urandom_range(0, 19) == 0) begin
					rt = 16'($urandom);
				end
				mt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4 * rt + 20));
				if ($urandom_range(0, 9) == 0) begin
					send(0, $urandom, POS_W'($urandom), 16'($urandom), 16'($urandom),
						POS_W'($urandom));
				end else begin
					run_move(($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 100)
						: $urandom, POS_W'($urandom), mt, rt, POS_W'($urandom),
						$urandom_range(0, 18));
				end
			end
		end
		no_pressure = 0;
		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/core/mpsg_pkg.sv
rtl/core/mpsg_req_if.sv
rtl/core/mpsg_rsp_if.sv
rtl/core/mpsg_cfg_if.sv
rtl/core/mpsg_alu.sv
rtl/core/motion_profile_setpoint_generator.sv
verif/motion_profile_setpoint_generator_checker.sv
verif/motion_profile_setpoint_generator_test.sv
